### rtl/s256_pkg.sv
// ----------------------------------------------------------------------------
// s256_pkg
// shared types, round constants and helper functions for the sha-256 unit
// ----------------------------------------------------------------------------
package s256_pkg;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PAD,
        ST_ROUNDS,
        ST_FOLD,
        ST_OUTPUT
    } ctrl_state_t;

    // request from the control sequencer to the compression core
    typedef struct packed {
        logic start;
        logic reinit;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### rtl/s256_core.sv
// ----------------------------------------------------------------------------
// s256_core
// compression core: message schedule ring, 64 rounds, hash word memory
// ----------------------------------------------------------------------------
module s256_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  s256_pkg::core_ctrl_t ctrl,
    output s256_pkg::core_stat_t stat,
    // block word fetch: word index out, registered word data back in the cycle after
    output logic [3:0]           blk_addr,
    input  logic [31:0]          blk_word,
    // digest read port
    input  logic [2:0]           hrd_addr,
    output logic [31:0]          hrd_data
);

    // hash word memory: one write and one registered read per cycle
    logic [31:0] hmem [8];
    logic [7:0]  hvalid_reg, hvalid_next;
    logic        hwe;
    logic [2:0]  hwa;
    logic [31:0] hwd;
    logic [2:0]  hra;
    logic [31:0] hrd_q;
    logic        hvq_reg;
    logic [2:0]  hra_q_reg;

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0] w_reg [16];
    logic [6:0]  rnd_reg, rnd_next;
    logic [3:0]  fold_reg, fold_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [1:0]  ph_reg, ph_next;

    localparam logic [1:0] PH_LOAD = 2'd0;
    localparam logic [1:0] PH_RND  = 2'd1;
    localparam logic [1:0] PH_FOLD = 2'd2;

    always_ff @(posedge clk)
    begin
        if (hwe)
        begin
            hmem[hwa] <= hwd;
        end
        hrd_q <= hmem[hra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvalid_reg <= '0;
            hvq_reg    <= 1'b0;
            hra_q_reg  <= '0;
        end
        else
        begin
            hvalid_reg <= hvalid_next;
            hvq_reg    <= hvalid_next[hra] & hvalid_reg[hra];
            hra_q_reg  <= hra;
        end
    end

    // an invalid entry reads as the initial hash value
    logic [31:0] hq;
    assign hq = hvq_reg ? hrd_q : s256_pkg::INIT_H[hra_q_reg];
    assign hrd_data = hq;

    // schedule word for round t
    logic [31:0] wt, s0w, s1w, wnew;
    always_comb
    begin
        s0w  = s256_pkg::rotr(w_reg[1], 7) ^ s256_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1w  = s256_pkg::rotr(w_reg[14], 17) ^ s256_pkg::rotr(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0w + w_reg[9] + s1w;
        wt   = (rnd_reg < 7'd16) ? w_reg[0] : wnew;
    end

    logic [31:0] t1, t2;
    always_comb
    begin
        t1 = h_reg + (s256_pkg::rotr(e_reg, 6) ^ s256_pkg::rotr(e_reg, 11)
             ^ s256_pkg::rotr(e_reg, 25)) + ((e_reg & f_reg) ^ (~e_reg & g_reg))
             + s256_pkg::round_k(rnd_reg[5:0]) + wt;
        t2 = (s256_pkg::rotr(a_reg, 2) ^ s256_pkg::rotr(a_reg, 13)
             ^ s256_pkg::rotr(a_reg, 22)) + ((a_reg & b_reg) ^ (a_reg & c_reg)
             ^ (b_reg & c_reg));
    end

    // phase control: the load phase fetches block words and hash words in step, then rounds and fold follow
    logic [31:0] hsel;
    always_comb
    begin
        ph_next     = ph_reg;
        rnd_next    = rnd_reg;
        fold_next   = fold_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        hvalid_next = hvalid_reg;
        hwe         = 1'b0;
        hwa         = fold_reg[2:0] - 3'd1;
        hwd         = '0;
        hra         = hrd_addr;
        blk_addr    = rnd_reg[3:0];
        hsel        = '0;
        if (ctrl.reinit)
        begin
            hvalid_next = '0;
        end
        case (ph_reg)
            PH_LOAD:
            begin
                if (busy_reg)
                begin
                    hra = rnd_reg[2:0];
                    rnd_next = rnd_reg + 7'd1;
                    if (rnd_reg == 7'd16)
                    begin
                        ph_next  = PH_RND;
                        rnd_next = '0;
                    end
                end
                else if (ctrl.start)
                begin
                    busy_next = 1'b1;
                    rnd_next  = '0;
                end
            end
            PH_RND:
            begin
                rnd_next = rnd_reg + 7'd1;
                hra = rnd_reg[2:0];
                if (rnd_reg == 7'd63)
                begin
                    ph_next   = PH_FOLD;
                    fold_next = '0;
                    hra       = 3'd0;
                end
            end
            PH_FOLD:
            begin
                // read word i through the registered port, then add and write the sum back to word i
                hra = fold_reg[2:0];
                fold_next = fold_reg + 4'd1;
                if (fold_reg != 4'd0)
                begin
                    case (fold_reg[2:0] - 3'd1)
                        3'd0: hsel = a_reg; 3'd1: hsel = b_reg;
                        3'd2: hsel = c_reg; 3'd3: hsel = d_reg;
                        3'd4: hsel = e_reg; 3'd5: hsel = f_reg;
                        3'd6: hsel = g_reg; default: hsel = h_reg;
                    endcase
                    hwe = 1'b1;
                    hwd = hq + hsel;
                    hvalid_next[hwa] = 1'b1;
                end
                if (fold_reg == 4'd8)
                begin
                    ph_next   = PH_LOAD;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    rnd_next  = '0;
                end
            end
            default: ph_next = PH_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_LOAD;
            rnd_reg  <= '0;
            fold_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            rnd_reg  <= rnd_next;
            fold_reg <= fold_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ph_reg == PH_LOAD && busy_reg)
        begin
            // block word for index rnd-1 arrives now; shift in at the top
            if (rnd_reg != 7'd0)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= blk_word;
            end
            // hash word rnd-1 arrives now, shift into the working set
            if (rnd_reg != 7'd0 && rnd_reg <= 7'd8)
            begin
                a_reg <= b_reg; b_reg <= c_reg; c_reg <= d_reg; d_reg <= e_reg;
                e_reg <= f_reg; f_reg <= g_reg; g_reg <= h_reg; h_reg <= hq;
            end
        end
        else if (ph_reg == PH_RND)
        begin
            // first 16 rounds rotate the loaded words, later rounds append
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= (rnd_reg < 7'd16) ? w_reg[0] : wnew;
            h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
        end
    end

    assign stat.busy = busy_reg | ctrl.start;
    assign stat.done = done_reg;

endmodule

### rtl/sha256_byte_stream_hash_unit.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hash_unit
// sha-256 over a byte stream, digest out as eight 32-bit words
// ----------------------------------------------------------------------------
// channel  dir  transaction
// s_axis   in   one byte (tdata), byte present (tuser), end of message (tlast)
// m_axis   out  one digest word (tdata), word index (tuser), final word (tlast)
//
// a byte is taken and written into the block buffer memory in the same cycle
// a full block stalls input while the core loads, runs its rounds and folds
// end of message pads one byte a cycle through offset 63, over one or two blocks
// digest words leave one at a time, each a registered hash memory read
// reset clears counts and marks all hash words as initial values
// ----------------------------------------------------------------------------
module sha256_byte_stream_hash_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // [0] byte_valid
    input  logic        s_axis_tlast,  // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,  // [2:0] word_index
    output logic        m_axis_tlast   // last_word
);

    s256_pkg::ctrl_state_t st_reg, st_next;
    s256_pkg::core_ctrl_t  cctl;
    s256_pkg::core_stat_t  cst;

    logic [63:0] cnt_reg, cnt_next;
    logic [5:0]  pad_reg, pad_next;
    logic        fin_reg, fin_next;     // pad sequence in progress
    logic        lenblk_reg, lenblk_next;  // current block carries length
    logic [3:0]  oidx_reg, oidx_next;
    logic        ov_reg, ov_next;
    logic [31:0] od_reg;
    logic [2:0]  oi_reg;
    logic        rd_pend_reg, rd_pend_next;

    // block buffer memory, 16 words of 4 bytes, byte write enables
    logic [31:0] bmem [16];
    logic        bwe;
    logic [5:0]  bwa;
    logic [7:0]  bwd;
    logic [3:0]  cbaddr;
    logic [31:0] cbword;

    always_ff @(posedge clk)
    begin
        if (bwe)
        begin
            case (bwa[1:0])
                2'd0: bmem[bwa[5:2]][31:24] <= bwd;
                2'd1: bmem[bwa[5:2]][23:16] <= bwd;
                2'd2: bmem[bwa[5:2]][15:8]  <= bwd;
                default: bmem[bwa[5:2]][7:0] <= bwd;
            endcase
        end
        cbword <= bmem[cbaddr];
    end

    logic [2:0] hra;
    logic [31:0] hrd;

    s256_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cctl),
        .stat     (cst),
        .blk_addr (cbaddr),
        .blk_word (cbword),
        .hrd_addr (hra),
        .hrd_data (hrd)
    );

    logic [63:0] bits;
    logic [5:0]  ptr;
    logic        take;
    assign bits = {cnt_reg[60:0], 3'b000};
    assign ptr  = cnt_reg[5:0];
    assign take = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        st_next     = st_reg;
        cnt_next    = cnt_reg;
        pad_next    = pad_reg;
        fin_next    = fin_reg;
        lenblk_next = lenblk_reg;
        oidx_next   = oidx_reg;
        rd_pend_next = 1'b0;
        s_axis_tready = 1'b0;
        bwe  = 1'b0;
        bwa  = ptr;
        bwd  = s_axis_tdata;
        cctl.start  = 1'b0;
        cctl.reinit = 1'b0;
        hra  = oidx_reg[2:0];
        case (st_reg)
            s256_pkg::ST_COLLECT:
            begin
                s_axis_tready = 1'b1;
                if (take)
                begin
                    if (s_axis_tuser)
                    begin
                        bwe = 1'b1;
                        cnt_next = cnt_reg + 64'd1;
                    end
                    if (s_axis_tlast)
                    begin
                        fin_next = 1'b1;
                        pad_next = s_axis_tuser ? ptr + 6'd1 : ptr;
                        lenblk_next = 1'b0;
                    end
                    if (s_axis_tuser && ptr == 6'd63)
                    begin
                        cctl.start = 1'b1;
                        st_next = s256_pkg::ST_ROUNDS;
                    end
                    else if (s_axis_tlast)
                    begin
                        st_next = s256_pkg::ST_PAD;
                    end
                end
            end
            s256_pkg::ST_PAD:
            begin
                // write one pad byte a cycle: 0x80, zeros, then length if this block carries it
                bwe = 1'b1;
                bwa = pad_reg;
                if (pad_reg == ptr && !lenblk_reg)
                begin
                    bwd = s256_pkg::PAD_BYTE;
                    if (pad_reg >= s256_pkg::LEN_OFFSET)
                    begin
                        lenblk_next = 1'b0;
                    end
                end
                else if (pad_reg >= s256_pkg::LEN_OFFSET && lenblk_reg)
                begin
                    case (pad_reg[2:0])
                        3'd0: bwd = bits[63:56]; 3'd1: bwd = bits[55:48];
                        3'd2: bwd = bits[47:40]; 3'd3: bwd = bits[39:32];
                        3'd4: bwd = bits[31:24]; 3'd5: bwd = bits[23:16];
                        3'd6: bwd = bits[15:8];  default: bwd = bits[7:0];
                    endcase
                end
                else
                begin
                    bwd = '0;
                end
                pad_next = pad_reg + 6'd1;
                // length fits when the pad byte lands below offset 56
                if (pad_reg == ptr && !lenblk_reg && pad_reg < s256_pkg::LEN_OFFSET)
                begin
                    lenblk_next = 1'b1;
                end
                if (pad_reg == 6'd63)
                begin
                    cctl.start = 1'b1;
                    st_next = s256_pkg::ST_ROUNDS;
                end
            end
            s256_pkg::ST_ROUNDS:
            begin
                if (cst.done)
                begin
                    if (!fin_reg)
                    begin
                        st_next = s256_pkg::ST_COLLECT;
                    end
                    else if (lenblk_reg)
                    begin
                        st_next = s256_pkg::ST_OUTPUT;
                        oidx_next = '0;
                    end
                    else
                    begin
                        // next pad block: zeros then length, led by the pad
                        // byte when the final byte filled a block exactly
                        st_next = s256_pkg::ST_PAD;
                        lenblk_next = (ptr != 6'd0);
                        pad_next = '0;
                    end
                end
            end
            s256_pkg::ST_OUTPUT:
            begin
                // one hash read in flight, issued once the output register frees
                if (!rd_pend_reg && (!ov_reg || m_axis_tready))
                begin
                    if (oidx_reg == 4'd8)
                    begin
                        st_next = s256_pkg::ST_COLLECT;
                        cctl.reinit = 1'b1;
                        cnt_next = '0;
                        fin_next = 1'b0;
                        lenblk_next = 1'b0;
                    end
                    else
                    begin
                        rd_pend_next = 1'b1;
                        oidx_next = oidx_reg + 4'd1;
                    end
                end
            end
            default: st_next = s256_pkg::ST_COLLECT;
        endcase
    end

    // pad byte lands in the first pad pass, or in the next after an exact block fill;
    // in a length block the message bytes are already gone, so the 0x80 test is skipped

    always_comb
    begin
        ov_next = ov_reg;
        if (m_axis_tready)
        begin
            ov_next = 1'b0;
        end
        if (rd_pend_reg)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= s256_pkg::ST_COLLECT;
            cnt_reg     <= '0;
            pad_reg     <= '0;
            fin_reg     <= 1'b0;
            lenblk_reg  <= 1'b0;
            oidx_reg    <= '0;
            ov_reg      <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            cnt_reg     <= cnt_next;
            pad_reg     <= pad_next;
            fin_reg     <= fin_next;
            lenblk_reg  <= lenblk_next;
            oidx_reg    <= oidx_next;
            ov_reg      <= ov_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            od_reg <= hrd;
            oi_reg <= oi_reg + 3'd1;
        end
        if (st_reg == s256_pkg::ST_ROUNDS)
        begin
            oi_reg <= 3'd7;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = oi_reg;
    assign m_axis_tlast  = (oi_reg == 3'd7);

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// byte-stream sha-256 unit: directed and random messages driven in bursts, each digest
// word checked against a behavioural hash kept in step with the input
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    byte_item_t   pending_bytes[$];
    digest_item_t expected_words[$];
    int           error_count;
    bit           hold_off_req;
    bit           hold_off_active;
    bit           in_accepted;

    // predictor state
    logic [31:0] model_hash [8];
    logic [63:0] model_count;
    logic [7:0]  model_block [64];

    sha256_byte_stream_hash_unit uut (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_model_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {model_block[4*i], model_block[4*i+1], model_block[4*i+2],
                    model_block[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            w[i] = w[i-16] + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = model_hash[i];
        end
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            model_hash[i] = model_hash[i] + v[i];
        end
    endtask

    task automatic restart_model();
        for (int i = 0; i < 8; i++)
        begin
            model_hash[i] = s256_pkg::INIT_H[i];
        end
        model_count = '0;
    endtask

    task automatic hash_byte(input byte_item_t it);
        logic [63:0] bit_len;
        int          fill;
        digest_item_t d;
        if (it.byte_valid)
        begin
            model_block[model_count[5:0]] = it.data_byte;
            model_count++;
            if (model_count[5:0] == 6'd0)
            begin
                compress_model_block();
            end
        end
        if (it.last_byte)
        begin
            bit_len = model_count << 3;
            fill = model_count[5:0];
            model_block[fill] = s256_pkg::PAD_BYTE;
            fill++;
            if (fill > s256_pkg::LEN_OFFSET)
            begin
                for (int i = fill; i < 64; i++)
                begin
                    model_block[i] = 8'h00;
                end
                compress_model_block();
                fill = 0;
            end
            for (int i = fill; i < s256_pkg::LEN_OFFSET; i++)
            begin
                model_block[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
            begin
                model_block[s256_pkg::LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
            end
            compress_model_block();
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = model_hash[i];
                d.word_index  = 3'(i);
                d.last_word   = (i == 7);
                expected_words.push_back(d);
            end
            restart_model();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    task automatic queue_message(input int len, input bit end_with_byte, input int noise);
        byte_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it.data_byte  = 8'($urandom);
            it.byte_valid = 1'b1;
            it.last_byte  = end_with_byte && (i == len - 1);
            pending_bytes.push_back(it);
            if (noise > 0 && $urandom_range(99) < noise)
            begin
                it.data_byte  = 8'($urandom);
                it.byte_valid = 1'b0;
                it.last_byte  = 1'b0;
                pending_bytes.push_back(it);
            end
        end
        if (!end_with_byte || len == 0)
        begin
            it.data_byte  = 8'($urandom);
            it.byte_valid = 1'b0;
            it.last_byte  = 1'b1;
            pending_bytes.push_back(it);
        end
    endtask

    // driver: bursts of random length, random gaps between them
    int burst_left;
    int gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            s_axis_tlast  <= 1'b0;
            burst_left    = 0;
            gap_left      = 0;
        end
        else if (!s_axis_tvalid || in_accepted)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                byte_item_t it;
                it = pending_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= it.data_byte;
                s_axis_tuser  <= it.byte_valid;
                s_axis_tlast  <= it.last_byte;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(40, 1);
                end
                burst_left--;
                if (burst_left == 0)
                begin
                    gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink ready: own stall pattern, plus a long hold-off on request
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready   <= 1'b0;
            hold_off_active = 1'b0;
        end
        else if (hold_off_req && !hold_off_active)
        begin
            hold_off_active = 1'b1;
            m_axis_tready <= 1'b0;
            repeat (400) @(negedge clk);
            m_axis_tready <= 1'b1;
            hold_off_active = 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(7) < 5) || ($realtime < 40000.0);
        end
    end

    // input monitor feeds the predictor, output monitor checks words
    always @(posedge clk)
    begin
        in_accepted = rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            byte_item_t it;
            it.data_byte  = s_axis_tdata;
            it.byte_valid = s_axis_tuser;
            it.last_byte  = s_axis_tlast;
            hash_byte(it);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("unexpected digest word", m_axis_tdata, 32'h0);
            end
            else
            begin
                digest_item_t d;
                d = expected_words.pop_front();
                if (m_axis_tdata !== d.digest_word)
                    report_mismatch("digest_word", m_axis_tdata, d.digest_word);
                if (m_axis_tuser !== d.word_index)
                    report_mismatch("word_index", 32'(m_axis_tuser), 32'(d.word_index));
                if (m_axis_tlast !== d.last_word)
                    report_mismatch("last_word", 32'(m_axis_tlast), 32'(d.last_word));
            end
        end
    end

    initial
    begin
        byte_item_t it;
        error_count  = 0;
        hold_off_req = 1'b0;
        restart_model();
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, padding boundaries, extreme bytes
        queue_message(0, 1'b0, 0);
        it = '{8'h00, 1'b1, 1'b1}; pending_bytes.push_back(it);
        it = '{8'hff, 1'b0, 1'b0}; pending_bytes.push_back(it);
        it = '{8'hff, 1'b1, 1'b1}; pending_bytes.push_back(it);
        queue_message(55, 1'b1, 0);
        queue_message(56, 1'b0, 0);
        queue_message(64, 1'b1, 0);
        wait (pending_bytes.size() == 0 && expected_words.size() == 0);

        // random messages, mostly short, now and then 60 to 130 bytes long
        for (int n = 0; n < 8; n++)
        begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(130, 60) : $urandom_range(30);
            queue_message(len, 1'($urandom), 15);
            if (n == 4)
            begin
                hold_off_req = 1'b1;
                wait (hold_off_active);
                hold_off_req = 1'b0;
            end
            wait (pending_bytes.size() < 20);
        end
        // short messages offered while the sink holds off
        hold_off_req = 1'b1;
        wait (hold_off_active);
        hold_off_req = 1'b0;
        queue_message(10, 1'b1, 0);
        queue_message(10, 1'b0, 0);
        wait (!hold_off_active);

        wait (pending_bytes.size() == 0 && !s_axis_tvalid && expected_words.size() == 0);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("sha256_byte_stream_hash_unit test passed");
        else
            $display("sha256_byte_stream_hash_unit test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("sha256_byte_stream_hash_unit test failed");
        $finish;
    end

endmodule

### files.f
rtl/s256_pkg.sv
rtl/s256_core.sv
rtl/sha256_byte_stream_hash_unit.sv
sim/testbench.sv
